FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared definitions for the ordered list table
// Command and status codes, field widths and the per-cell control struct.
// ----------------------------------------------------------------------------
package olt_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 16;
   localparam int LETTER_W = 8;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int ENTRY_W  = 5;

   // default table depth
   localparam int DEFAULT_CAPACITY = 16;

   // cells inspected per cycle by the first-hit scan
   localparam int SCAN_GROUP   = 8;
   localparam int SCAN_GROUP_W = 3;

   // command codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // per-cell load controls
   typedef struct packed {
      logic load_new;
      logic load_left;
      logic load_right;
   } cell_ctl_type;

endpackage

FILE: rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell: one record slot of the ordered list table
// Holds a key and a letter, loads from the new record or from either
// neighbour, and compares its key with the probe key.
// ----------------------------------------------------------------------------
module olt_cell import olt_pkg::*; (
   input  logic                       clock,
   input  cell_ctl_type               ctl,
   input  logic signed [KEY_W-1:0]    new_key,
   input  logic [LETTER_W-1:0]        new_letter,
   input  logic signed [KEY_W-1:0]    left_key,
   input  logic [LETTER_W-1:0]        left_letter,
   input  logic signed [KEY_W-1:0]    right_key,
   input  logic [LETTER_W-1:0]        right_letter,
   input  logic signed [KEY_W-1:0]    probe_key,
   input  logic                       probe_exact,
   output logic signed [KEY_W-1:0]    key,
   output logic [LETTER_W-1:0]        letter,
   output logic                       hit
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   logic [LETTER_W-1:0]     letter_ff;
   logic [LETTER_W-1:0]     letter_in;

   // load selection
   always_comb begin
      key_in    = key_ff;
      letter_in = letter_ff;
      if (ctl.load_new) begin
         key_in    = new_key;
         letter_in = new_letter;
      end else if (ctl.load_left) begin
         key_in    = left_key;
         letter_in = left_letter;
      end else if (ctl.load_right) begin
         key_in    = right_key;
         letter_in = right_letter;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      letter_ff <= letter_in;
   end

   // equal match for search, first greater-or-equal for sorted insert
   assign hit    = probe_exact ? (probe_key == key_ff) : (probe_key <= key_ff);
   assign key    = key_ff;
   assign letter = letter_ff;

endmodule

FILE: rtl/ordered_list_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_table_unit: bounded list of keyed records
// Deque and sorted list of CAPACITY records held in a row of cells.
// ----------------------------------------------------------------------------
// Each request is one command and gives one response. Push, pop and unused
// commands pass from the examine state straight to the apply state; search
// and sorted insert pass through the scan state between them, which walks
// the cells in 8-cell groups until it finds a hit or runs out of groups.
// Requests are taken one at a time: the next request is accepted in the cycle
// after the response is formed, and a command may first wait in the apply
// state for the output register to free up.
// A finished response may wait in the output register while the next request
// is accepted.
module ordered_list_table_unit import olt_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_operation,
   input  logic signed [KEY_W-1:0]    req_item_key,
   input  logic [LETTER_W-1:0]        req_item_letter,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [KEY_W-1:0]    rsp_out_key,
   output logic [LETTER_W-1:0]        rsp_out_letter,
   output logic [INDEX_W-1:0]         rsp_found_index,
   output logic [ENTRY_W-1:0]         rsp_entry_count
);

   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int NGROUP    = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int HIT_W     = NGROUP * SCAN_GROUP;
   localparam int LAST_BASE = (NGROUP - 1) * SCAN_GROUP;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HIT   = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [LETTER_W-1:0]     letter_ff, letter_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        base_ff, base_in;
   logic [HIT_W-1:0]        hit_ff, hit_in;
   logic                    found_ff, found_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic signed [KEY_W-1:0] okey_ff, okey_in;
   logic [LETTER_W-1:0]     olet_ff, olet_in;
   logic [INDEX_W-1:0]      oidx_ff, oidx_in;
   logic [ENTRY_W-1:0]      ocnt_ff, ocnt_in;

   logic signed [KEY_W-1:0] cell_key    [CAPACITY];
   logic [LETTER_W-1:0]     cell_letter [CAPACITY];
   logic [CAPACITY-1:0]     cell_hit;
   cell_ctl_type            cell_ctl    [CAPACITY];

   logic                    req_fire;
   logic                    apply_fire;
   logic                    is_push;
   logic                    is_pop;
   logic                    do_ins;
   logic                    do_pop;
   logic                    group_any;
   logic [SCAN_GROUP_W-1:0] group_off;
   logic signed [KEY_W-1:0] sel_key;
   logic [LETTER_W-1:0]     sel_letter;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);

   assign is_push = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK) ||
                    (op_ff == OP_INSERT);
   assign is_pop  = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK);
   assign do_ins  = apply_fire && is_push && (count_ff != CNT_W'(CAPACITY));
   assign do_pop  = apply_fire && is_pop && (count_ff != '0);

   // row of record cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key, right_key;
      logic [LETTER_W-1:0]     left_letter, right_letter;

      if (i == 0) begin : g_first
         assign left_key    = key_ff;
         assign left_letter = letter_ff;
      end else begin : g_mid_l
         assign left_key    = cell_key[i-1];
         assign left_letter = cell_letter[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key    = '0;
         assign right_letter = '0;
      end else begin : g_mid_r
         assign right_key    = cell_key[i+1];
         assign right_letter = cell_letter[i+1];
      end

      // cell action from its place relative to the working position
      assign cell_ctl[i].load_new   = do_ins && (CNT_W'(i) == pos_ff);
      assign cell_ctl[i].load_left  = do_ins && (CNT_W'(i) > pos_ff);
      assign cell_ctl[i].load_right = do_pop && (CNT_W'(i) >= pos_ff);

      olt_cell u_cell (
         .clock        (clock),
         .ctl          (cell_ctl[i]),
         .new_key      (key_ff),
         .new_letter   (letter_ff),
         .left_key     (left_key),
         .left_letter  (left_letter),
         .right_key    (right_key),
         .right_letter (right_letter),
         .probe_key    (key_ff),
         .probe_exact  (op_ff == OP_SEARCH),
         .key          (cell_key[i]),
         .letter       (cell_letter[i]),
         .hit          (cell_hit[i])
      );
   end

   // record at the working position
   always_comb begin
      sel_key    = '0;
      sel_letter = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CNT_W'(i) == pos_ff) begin
            sel_key    = sel_key | cell_key[i];
            sel_letter = sel_letter | cell_letter[i];
         end
      end
   end

   // first hit within the current scan group
   always_comb begin
      group_any = |hit_ff[SCAN_GROUP-1:0];
      group_off = '0;
      for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
         if (hit_ff[k]) begin
            group_off = SCAN_GROUP_W'(k);
         end
      end
   end

   // command sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      letter_in = letter_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      base_in   = base_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_operation;
               key_in    = req_item_key;
               letter_in = req_item_letter;
               state_in  = S_HIT;
            end
         end
         S_HIT: begin
            found_in = 1'b0;
            base_in  = '0;
            pos_in   = count_ff;
            hit_in   = '0;
            for (int i = 0; i < CAPACITY; i++) begin
               hit_in[i] = cell_hit[i] && (CNT_W'(i) < count_ff);
            end
            state_in = S_APPLY;
            case (op_ff)
               OP_PUSH_FRONT, OP_POP_FRONT: pos_in = '0;
               OP_POP_BACK:                 pos_in = count_ff - CNT_W'(1);
               OP_SEARCH, OP_INSERT:        state_in = S_SCAN;
               default:                     pos_in = count_ff;
            endcase
         end
         S_SCAN: begin
            if (group_any) begin
               pos_in   = CNT_W'(base_ff) + CNT_W'(group_off);
               found_in = 1'b1;
               state_in = S_APPLY;
            end else if (base_ff == IDX_W'(LAST_BASE)) begin
               state_in = S_APPLY;
            end else begin
               hit_in  = hit_ff >> SCAN_GROUP;
               base_in = base_ff + IDX_W'(SCAN_GROUP);
            end
         end
         S_APPLY: begin
            if (apply_fire) begin
               if (do_ins) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (do_pop) begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // response formation
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      okey_in      = okey_ff;
      olet_in      = olet_ff;
      oidx_in      = oidx_ff;
      ocnt_in      = ocnt_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         okey_in      = '0;
         olet_in      = '0;
         oidx_in      = '0;
         ocnt_in      = ENTRY_W'(count_in);
         if (is_push) begin
            if (!do_ins) begin
               status_in = ST_FULL;
            end
         end else if (is_pop) begin
            if (do_pop) begin
               okey_in = sel_key;
               olet_in = sel_letter;
            end else begin
               status_in = ST_EMPTY;
            end
         end else if (op_ff == OP_SEARCH) begin
            if (found_ff) begin
               okey_in = sel_key;
               olet_in = sel_letter;
               oidx_in = INDEX_W'(pos_ff);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      letter_ff <= letter_in;
      pos_ff    <= pos_in;
      base_ff   <= base_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      okey_ff   <= okey_in;
      olet_ff   <= olet_in;
      oidx_ff   <= oidx_in;
      ocnt_ff   <= ocnt_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = okey_ff;
   assign rsp_out_letter  = olet_ff;
   assign rsp_found_index = oidx_ff;
   assign rsp_entry_count = ocnt_ff;

   // record count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("record count beyond capacity");

   // record count moves by at most one per request
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("record count jumped");

   // an accepted request is examined in the next cycle
   a_accept_hit: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_HIT))
      else $error("request not taken into the sequencer");

   // empty status only with an empty table
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with records present");

   // a finished command always leaves a response behind
   a_apply_rsp: assert property (@(posedge clock) disable iff (reset)
      apply_fire |=> rsp_valid_ff)
      else $error("command finished without a response");

endmodule
